>>> sv/sks_pkg.sv
`default_nettype none

package sks_pkg;

    localparam int GAIN_FRAC_BITS = 16;
    localparam int SAMPLE_WIDTH   = 10;

    localparam int VAR_W     = 24;
    localparam int VAR_FRAC  = 16;
    localparam int EST_W     = 19;
    localparam int EST_FRAC  = 8;
    localparam int REG_W     = 8;
    localparam int CFG_IDX_W = 2;

    localparam int S_TDATA_W = ((SAMPLE_WIDTH + 7) / 8) * 8;
    localparam int M_TDATA_W = ((EST_W + GAIN_FRAC_BITS + VAR_W + 7) / 8) * 8;

    localparam logic [CFG_IDX_W-1:0] REG_NOISE    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_INIT_VAR = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BASELINE = 2'd2;

    localparam logic [REG_W-1:0] NOISE_RST    = 8'd5;
    localparam logic [REG_W-1:0] INIT_VAR_RST = 8'd4;

    localparam int STEP_W = 3;

    // micro operations
    localparam logic [2:0] OP_NOP   = 3'd0;
    localparam logic [2:0] OP_LOAD  = 3'd1;
    localparam logic [2:0] OP_INNOV = 3'd2;
    localparam logic [2:0] OP_DIV   = 3'd3;
    localparam logic [2:0] OP_SAT   = 3'd4;
    localparam logic [2:0] OP_MULE  = 3'd5;
    localparam logic [2:0] OP_MULP  = 3'd6;
    localparam logic [2:0] OP_UPD   = 3'd7;

    // jump conditions
    localparam logic [2:0] JC_NONE     = 3'd0;
    localparam logic [2:0] JC_ALWAYS   = 3'd1;
    localparam logic [2:0] JC_NO_IN    = 3'd2;
    localparam logic [2:0] JC_R_ZERO   = 3'd3;
    localparam logic [2:0] JC_DIV_MORE = 3'd4;
    localparam logic [2:0] JC_OUT_BUSY = 3'd5;

    typedef struct packed {
        logic [2:0]        op;
        logic [2:0]        cond;
        logic [STEP_W-1:0] target;
    } uword_t;

    function automatic uword_t ucode(input logic [STEP_W-1:0] step);
        uword_t w;
        unique case (step)
            3'd0:    w = '{op: OP_LOAD,  cond: JC_NO_IN,    target: 3'd0};
            3'd1:    w = '{op: OP_INNOV, cond: JC_R_ZERO,   target: 3'd4};
            3'd2:    w = '{op: OP_DIV,   cond: JC_DIV_MORE, target: 3'd2};
            3'd3:    w = '{op: OP_NOP,   cond: JC_ALWAYS,   target: 3'd5};
            3'd4:    w = '{op: OP_SAT,   cond: JC_NONE,     target: 3'd0};
            3'd5:    w = '{op: OP_MULE,  cond: JC_NONE,     target: 3'd0};
            3'd6:    w = '{op: OP_MULP,  cond: JC_NONE,     target: 3'd0};
            3'd7:    w = '{op: OP_UPD,   cond: JC_OUT_BUSY, target: 3'd7};
            default: w = '{op: OP_NOP,   cond: JC_NONE,     target: 3'd0};
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

>>> sv/scalar_kalman_smoother.sv
// channel  | dir | handshake            | payload
// ---------+-----+----------------------+---------------------------------------------
// s_axis   | in  | s_tvalid / s_tready  | s_tdata: sample; s_tuser: restart
// m_axis   | out | m_tvalid / m_tready  | m_tdata: estimate, gain, variance
// cfg      | in  | cfg_valid/cfg_ready  | cfg_index, cfg_data
//
// a result is registered at the update step; the gain comes from the bit-serial gain divider,
// one quotient bit per cycle of the microprogram; when R is zero the divider is skipped
// and the gain saturates; the next request is taken only once the current one has passed its update step
// reset: asynchronous active low, registers to 5, 4, 0, estimate 0, variance 4.0
// a stalled output holds the program at its update step until the slot frees
`default_nettype none

module scalar_kalman_smoother (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    input  wire logic [sks_pkg::S_TDATA_W-1:0]     s_tdata,   // sample
    input  wire logic                              s_tuser,   // restart
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    output logic [sks_pkg::M_TDATA_W-1:0]          m_tdata,   // estimate, gain, variance
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [sks_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [sks_pkg::SAMPLE_WIDTH-1:0]  cfg_data
);
    import sks_pkg::*;

    localparam int G       = GAIN_FRAC_BITS;
    localparam int SW      = SAMPLE_WIDTH;
    localparam int CNT_W   = $clog2(G);
    localparam int DEN_W   = VAR_W + 1;
    localparam int ZS_W    = SW + EST_FRAC;
    localparam int INNOV_W = ((ZS_W > EST_W) ? ZS_W : EST_W) + 1;
    localparam int PE_W    = INNOV_W + G + 1;
    localparam int STEP_E  = PE_W - G;
    localparam int SUM_W   = ((STEP_E > EST_W) ? STEP_E : EST_W) + 1;
    localparam int PP_W    = VAR_W + G + 1;
    localparam int OUT_W   = EST_W + G + VAR_W;

    localparam logic signed [PE_W-1:0]  HALF_E  = PE_W'(1) <<< (G - 1);
    localparam logic [PP_W-1:0]         HALF_P  = PP_W'(1) << (G - 1);
    localparam logic [G:0]              ONE     = (G + 1)'(1) << G;
    localparam logic signed [SUM_W-1:0] EST_MAX = SUM_W'((64'sd1 <<< (EST_W - 1)) - 1);
    localparam logic signed [SUM_W-1:0] EST_MIN = -SUM_W'(64'sd1 <<< (EST_W - 1));

    // configuration
    logic [REG_W-1:0]     noise_reg;
    logic [REG_W-1:0]     init_var_reg;
    logic signed [SW-1:0] base_reg;

    // sequencer
    logic [STEP_W-1:0] step_reg;
    logic [STEP_W-1:0] step_next;
    logic [CNT_W-1:0]  cnt_reg;
    uword_t            uw;
    logic              jump;

    // datapath
    logic signed [SW-1:0]      z_reg;
    logic [VAR_W-1:0]          p_reg;
    logic [DEN_W-1:0]          den_reg;
    logic [DEN_W-1:0]          rem_reg;
    logic [G-1:0]              gain_reg;
    logic signed [INNOV_W-1:0] innov_reg;
    logic signed [PE_W-1:0]    prod_e_reg;
    logic [PP_W-1:0]           prod_p_reg;
    logic signed [EST_W-1:0]   est_reg;
    logic [VAR_W-1:0]          var_reg;

    logic                  m_tvalid_reg;
    logic [OUT_W-1:0]      m_data_reg;

    logic                  in_accept;
    logic                  out_free;
    logic                  upd_fire;
    logic signed [SW:0]    diff;
    logic [VAR_W-1:0]      p_load;
    logic [DEN_W:0]        rem_shift;
    logic                  qbit;
    logic [DEN_W-1:0]      rem_next;
    logic signed [PE_W-1:0]    prod_e_rnd;
    logic signed [STEP_E-1:0]  est_step;
    logic signed [SUM_W-1:0]   est_sum;
    logic signed [EST_W-1:0]   est_next;
    logic [PP_W-1:0]           prod_p_rnd;
    logic [VAR_W-1:0]          var_next;
    logic [G:0]                one_minus_gain;

    assign uw        = ucode(step_reg);
    assign s_tready  = (uw.op == OP_LOAD);
    assign in_accept = s_tvalid && s_tready;
    assign out_free  = !m_tvalid_reg || m_tready;
    assign upd_fire  = (uw.op == OP_UPD) && out_free;
    assign cfg_ready = 1'b1;

    always_comb
    begin
        unique case (uw.cond)
            JC_ALWAYS:   jump = 1'b1;
            JC_NO_IN:    jump = !s_tvalid;
            JC_R_ZERO:   jump = (noise_reg == '0);
            JC_DIV_MORE: jump = (cnt_reg != CNT_W'(G - 1));
            JC_OUT_BUSY: jump = !out_free;
            default:     jump = 1'b0;
        endcase
        step_next = jump ? uw.target : step_reg + STEP_W'(1);
    end

    // measurement and variance at load
    assign diff   = $signed({s_tdata[SW-1], s_tdata[SW-1:0]}) - $signed({base_reg[SW-1], base_reg});
    assign p_load = s_tuser ? {init_var_reg, {VAR_FRAC{1'b0}}} : var_reg;

    // restoring divide step
    assign rem_shift = {rem_reg, 1'b0};
    assign qbit      = (rem_shift >= {1'b0, den_reg});
    assign rem_next  = qbit ? DEN_W'(rem_shift - {1'b0, den_reg}) : rem_shift[DEN_W-1:0];

    assign one_minus_gain = ONE - {1'b0, gain_reg};

    // update
    assign prod_e_rnd = prod_e_reg + HALF_E;
    assign est_step   = prod_e_rnd[PE_W-1:G];
    assign est_sum    = SUM_W'(est_reg) + SUM_W'(est_step);
    always_comb
    begin
        priority if (est_sum > EST_MAX)
            est_next = EST_MAX[EST_W-1:0];
        else if (est_sum < EST_MIN)
            est_next = EST_MIN[EST_W-1:0];
        else
            est_next = est_sum[EST_W-1:0];
    end
    assign prod_p_rnd = prod_p_reg + HALF_P;
    assign var_next   = prod_p_rnd[G+VAR_W-1:G];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            noise_reg    <= NOISE_RST;
            init_var_reg <= INIT_VAR_RST;
            base_reg     <= '0;
            step_reg     <= '0;
            cnt_reg      <= '0;
            est_reg      <= '0;
            var_reg      <= {INIT_VAR_RST, {VAR_FRAC{1'b0}}};
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            step_reg <= step_next;
            if (cfg_valid)
            begin
                unique case (cfg_index)
                    REG_NOISE:    noise_reg    <= cfg_data[REG_W-1:0];
                    REG_INIT_VAR: init_var_reg <= cfg_data[REG_W-1:0];
                    REG_BASELINE: base_reg     <= cfg_data;
                    default:      ;
                endcase
            end
            if (in_accept)
                cnt_reg <= '0;
            else if (uw.op == OP_DIV)
                cnt_reg <= cnt_reg + CNT_W'(1);
            if (upd_fire)
            begin
                est_reg <= est_next;
                var_reg <= var_next;
            end
            if (upd_fire)
                m_tvalid_reg <= 1'b1;
            else if (m_tready)
                m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            z_reg   <= diff[SW:1];
            p_reg   <= p_load;
            den_reg <= DEN_W'(p_load) + DEN_W'({noise_reg, {VAR_FRAC{1'b0}}});
            rem_reg <= DEN_W'(p_load);
        end
        unique case (uw.op)
            OP_INNOV: innov_reg <= INNOV_W'(z_reg) * INNOV_W'(2 ** EST_FRAC) - INNOV_W'(est_reg);
            OP_DIV:
            begin
                rem_reg  <= rem_next;
                gain_reg <= {gain_reg[G-2:0], qbit};
            end
            OP_SAT:   gain_reg   <= (p_reg != '0) ? '1 : '0;
            OP_MULE:  prod_e_reg <= PE_W'($signed({1'b0, gain_reg})) * PE_W'(innov_reg);
            OP_MULP:  prod_p_reg <= PP_W'(p_reg) * PP_W'(one_minus_gain);
            default:  ;
        endcase
        if (upd_fire)
            m_data_reg <= {var_next, gain_reg, est_next};
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = M_TDATA_W'(m_data_reg);

endmodule

`default_nettype wire

>>> tb/tb_scalar_kalman_smoother.sv
`default_nettype none

module tb_scalar_kalman_smoother;
    import sks_pkg::*;

    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
    localparam longint GAIN_ONE     = longint'(1) << GAIN_FRAC_BITS;
    localparam longint EST_HI       = (longint'(1) << (EST_W - 1)) - 1;
    localparam longint EST_LO       = -(longint'(1) << (EST_W - 1));
    localparam int     DRAIN_CYCLES = 40;
    localparam int     HOLD_CYCLES  = 400;
    localparam int     MAX_REPORTS  = 10;

    typedef struct packed {
        logic [VAR_W-1:0]          variance;
        logic [GAIN_FRAC_BITS-1:0] gain;
        logic [EST_W-1:0]          estimate;
    } smoothed_t;

    logic                    clk;
    logic                    rst_n;
    logic                    s_tvalid;
    logic                    s_tready;
    logic [S_TDATA_W-1:0]    s_tdata;   // sample
    logic                    s_tuser;   // restart
    logic                    m_tvalid;
    logic                    m_tready;
    logic [M_TDATA_W-1:0]    m_tdata;   // estimate, gain, variance
    logic                    cfg_valid;
    logic                    cfg_ready;
    logic [CFG_IDX_W-1:0]    cfg_index;
    logic [SAMPLE_WIDTH-1:0] cfg_data;

    // mirror of the block state and registers
    logic [REG_W-1:0]               noise_cfg;
    logic [REG_W-1:0]               ivar_cfg;
    logic signed [SAMPLE_WIDTH-1:0] base_cfg;
    longint                         est_state;
    logic [VAR_W-1:0]               var_state;

    smoothed_t pending_results[$];
    int        mismatch_count;
    int        send_idle_pct;
    int        recv_stall_pct;
    int        hold_requests;

    scalar_kalman_smoother dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    function automatic smoothed_t kalman_update(input logic signed [SAMPLE_WIDTH-1:0] smp,
                                                input logic reload);
        longint    z;
        longint    p;
        longint    den;
        longint    g;
        longint    innov;
        longint    est;
        smoothed_t r;
        z = (longint'(smp) - longint'(base_cfg)) >>> 1;
        if (reload)
        begin
            var_state = VAR_W'(longint'(ivar_cfg) << VAR_FRAC);
        end
        p   = longint'(var_state);
        den = p + (longint'(noise_cfg) << VAR_FRAC);
        if (den == 0)
        begin
            g = 0;
        end
        else
        begin
            g = (p << GAIN_FRAC_BITS) / den;
        end
        if (g > GAIN_ONE - 1)
        begin
            g = GAIN_ONE - 1;
        end
        innov = z * (longint'(1) << EST_FRAC) - est_state;
        est   = est_state + ((g * innov + (GAIN_ONE >> 1)) >>> GAIN_FRAC_BITS);
        if (est > EST_HI)
        begin
            est = EST_HI;
        end
        if (est < EST_LO)
        begin
            est = EST_LO;
        end
        est_state  = est;
        var_state  = VAR_W'((p * (GAIN_ONE - g) + (GAIN_ONE >> 1)) >> GAIN_FRAC_BITS);
        r.estimate = EST_W'(est);
        r.gain     = GAIN_FRAC_BITS'(g);
        r.variance = var_state;
        return r;
    endfunction

    task automatic send_sample(input logic [SAMPLE_WIDTH-1:0] smp, input logic reload);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(S_TDATA_W - SAMPLE_WIDTH){1'b0}}, smp};
        s_tuser  <= reload;
        do
            @(posedge clk);
        while (!s_tready);
        pending_results.push_back(kalman_update(smp, reload));
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [SAMPLE_WIDTH-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            REG_NOISE:    noise_cfg = val[REG_W-1:0];
            REG_INIT_VAR: ivar_cfg  = val[REG_W-1:0];
            REG_BASELINE: base_cfg  = val;
            default:      ;
        endcase
    endtask

    task automatic configure(input logic [SAMPLE_WIDTH-1:0] noise_w,
                             input logic [SAMPLE_WIDTH-1:0] ivar_w,
                             input logic [SAMPLE_WIDTH-1:0] base_w);
        cfg_write(REG_NOISE, noise_w);
        cfg_write(REG_UNUSED, SAMPLE_WIDTH'($urandom_range(1023)));
        cfg_write(REG_INIT_VAR, ivar_w);
        cfg_write(REG_BASELINE, base_w);
        cfg_valid <= 1'b0;
    endtask

    task automatic wait_drain();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    function automatic logic [SAMPLE_WIDTH-1:0] pick_reg();
        logic [SAMPLE_WIDTH-1:0] v;
        v[SAMPLE_WIDTH-1:REG_W] = (SAMPLE_WIDTH - REG_W)'(($urandom_range(3) == 0) ?
                                                          $urandom_range(3) : 0);
        case ($urandom_range(4))
            0:       v[REG_W-1:0] = 8'd0;
            1:       v[REG_W-1:0] = 8'd1;
            2:       v[REG_W-1:0] = 8'd255;
            default: v[REG_W-1:0] = REG_W'($urandom_range(255));
        endcase
        return v;
    endfunction

    task automatic test_directed();
        send_sample(10'sd0, 1'b0);
        send_sample(10'sd511, 1'b0);
        send_sample(-10'sd512, 1'b0);
        send_sample(10'sd1, 1'b1);
        wait_drain();
        // zero noise: gain saturates just below one
        configure(10'd0, 10'd255, -10'sd512);
        send_sample(10'sd511, 1'b1);
        send_sample(-10'sd512, 1'b0);
        wait_drain();
        // zero noise and zero variance: zero denominator
        configure(10'd0, 10'd0, 10'sd511);
        send_sample(-10'sd512, 1'b1);
        send_sample(-10'sd511, 1'b0);
        send_sample(10'sd0, 1'b0);
        wait_drain();
        // upper data bits of the 8-bit registers are dropped
        configure({2'b11, 8'd255}, {2'b10, 8'd1}, 10'sd0);
        send_sample(-10'sd1, 1'b1);
        send_sample(10'sd1, 1'b0);
        send_sample(10'sd3, 1'b0);
        wait_drain();
        configure(10'd1, 10'd255, -10'sd1);
        send_sample(10'sd100, 1'b1);
        send_sample(10'sd200, 1'b0);
        send_sample(-10'sd300, 1'b0);
        wait_drain();
        configure(10'd255, 10'd255, 10'sd511);
        send_sample(10'sd511, 1'b1);
        send_sample(-10'sd512, 1'b0);
    endtask

    task automatic test_random_stream(input int count, input int send_pct, input int recv_pct);
        int   level;
        int   smp;
        logic reload;
        wait_drain();
        configure(pick_reg(), pick_reg(), SAMPLE_WIDTH'($urandom_range(1023)));
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
        level = $urandom_range(1023);
        for (int i = 0; i < count; i++)
        begin
            if ($urandom_range(39) == 0)
            begin
                level = $urandom_range(1023);
            end
            reload = ($urandom_range(15) == 0);
            if ($urandom_range(7) == 0)
            begin
                smp = $urandom_range(1023);
            end
            else
            begin
                smp = level + $urandom_range(32) - 16;
            end
            send_sample(SAMPLE_WIDTH'(smp), reload);
        end
    endtask

    task automatic test_backpressure();
        wait_drain();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_requests  = hold_requests + 1;
        for (int i = 0; i < 40; i++)
        begin
            send_sample(SAMPLE_WIDTH'($urandom_range(1023)), ($urandom_range(7) == 0));
        end
    endtask

    task automatic test_drain_pause();
        send_idle_pct  = 0;
        recv_stall_pct = 30;
        for (int i = 0; i < 10; i++)
        begin
            send_sample(SAMPLE_WIDTH'($urandom_range(1023)), (i == 0));
        end
        wait_drain();
        for (int i = 0; i < 10; i++)
        begin
            send_sample(SAMPLE_WIDTH'($urandom_range(1023)), 1'b0);
        end
    endtask

    initial
    begin : result_sink
        int hold_left;
        int hold_served;
        hold_left   = 0;
        hold_served = 0;
        m_tready    = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_served != hold_requests)
            begin
                hold_served = hold_requests;
                hold_left   = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left = hold_left - 1;
                m_tready <= 1'b0;
            end
            else
            begin
                m_tready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    always @(posedge clk)
    begin : result_check
        smoothed_t got;
        smoothed_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = smoothed_t'(m_tdata[EST_W + GAIN_FRAC_BITS + VAR_W - 1:0]);
            if (pending_results.size() == 0)
            begin
                mismatch_count = mismatch_count + 1;
                if (mismatch_count <= MAX_REPORTS)
                begin
                    $display("unexpected result: est %0d gain %0d var %0d",
                             $signed(got.estimate), got.gain, got.variance);
                end
            end
            else
            begin
                want = pending_results.pop_front();
                if (got.estimate != want.estimate || got.gain != want.gain
                    || got.variance != want.variance)
                begin
                    mismatch_count = mismatch_count + 1;
                    if (mismatch_count <= MAX_REPORTS)
                    begin
                        $display("mismatch: expected est %0d gain %0d var %0d, got est %0d gain %0d var %0d",
                                 $signed(want.estimate), want.gain, want.variance,
                                 $signed(got.estimate), got.gain, got.variance);
                    end
                end
            end
        end
    end

    initial
    begin
        rst_n          = 1'b0;
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        s_tuser        = 1'b0;
        cfg_valid      = 1'b0;
        cfg_index      = REG_NOISE;
        cfg_data       = '0;
        mismatch_count = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_requests  = 0;
        noise_cfg      = NOISE_RST;
        ivar_cfg       = INIT_VAR_RST;
        base_cfg       = '0;
        est_state      = 0;
        var_state      = VAR_W'(longint'(INIT_VAR_RST) << VAR_FRAC);
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_random_stream(500, 0, 0);
        test_random_stream(500, 81, 0);
        test_random_stream(500, 0, 81);
        test_random_stream(500, 30, 30);
        test_backpressure();
        test_drain_pause();
        wait_drain();
        if (mismatch_count == 0 && pending_results.size() == 0)
        begin
            $display("simulation ok");
        end
        else
        begin
            $display("simulation failed");
        end
        $finish;
    end

    initial
    begin
        #2000000;
        $display("simulation failed");
        $finish;
    end

endmodule

`default_nettype wire
